// File: hw/rtl/wst_pkg.sv
// shared types, sizes and codes for the weighted semaphore table
`default_nettype none

package wst_pkg;

  localparam int NUM_SEMS   = 64;
  localparam int WAIT_DEPTH = 8;

  localparam int SEM_IDX_W = 6;
  localparam int AMOUNT_W  = 16;
  localparam int WAITER_W  = 8;
  localparam int FREE_W    = 32;

  localparam int SEM_AW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int SLOT_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int LEN_W  = $clog2(WAIT_DEPTH + 1);

  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_WAIT    = 2'd2;
  localparam logic [1:0] OP_SIGNAL  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]           operation;
    logic [SEM_IDX_W-1:0] sem_index;
    logic [AMOUNT_W-1:0]  amount;
    logic [WAITER_W-1:0]  waiter_id;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                queued;
    logic                woke_valid;
    logic [WAITER_W-1:0] woke_id;
  } rsp_t;

  typedef struct packed {
    logic              active;
    logic [FREE_W-1:0] free;
    logic [LEN_W-1:0]  len;
  } sem_ent_t;

  typedef struct packed {
    logic [AMOUNT_W-1:0] amount;
    logic [WAITER_W-1:0] waiter;
  } q_ent_t;

endpackage

`default_nettype wire

// File: hw/rtl/wst_ram.sv
// generic single write port, single registered read port ram
`default_nettype none

module wst_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [(1 << AW)];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/wst_alu.sv
// shared 32-bit add/subtract unit with carry or borrow flag
`default_nettype none

module wst_alu (
  input  wire logic [wst_pkg::FREE_W-1:0] a_i,
  input  wire logic [wst_pkg::FREE_W-1:0] b_i,
  input  wire logic                       sub_i,
  output logic      [wst_pkg::FREE_W-1:0] res_o,
  output logic                            flag_o
);
  import wst_pkg::*;

  logic [FREE_W:0] sum;
  logic [FREE_W-1:0] b_op;

  assign b_op  = sub_i ? ~b_i : b_i;
  assign sum   = {1'b0, a_i} + {1'b0, b_op} + {{FREE_W{1'b0}}, sub_i};
  assign res_o = sum[FREE_W-1:0];
  // add: carry out, sub: borrow
  assign flag_o = sub_i ? ~sum[FREE_W] : sum[FREE_W];

endmodule

`default_nettype wire

// File: hw/rtl/weighted_semaphore_table.sv
// weighted semaphore table: sequencer, semaphore table, wait queues
//
//   channel | dir | handshake                 | payload
//   request | in  | req_valid_i / req_stall_o | req_i (wst_pkg::req_t)
//   result  | out | rsp_valid_o / rsp_stall_i | rsp_o (wst_pkg::rsp_t)
//
// init, destroy, wait: accept, table read, result load
// signal: accept, table read, then k queue entries scanned through the shared
//   adder (one per cycle), m entries moved up during compaction, then result
//   load; k + m never exceeds the queue length; scan and compaction share the
//   single queue memory port
// reset clears per-semaphore valid bits at once; no clearing pass
// the next request is taken while a result still waits; a stalled result
// holds the sequencer in its last step
`default_nettype none

module weighted_semaphore_table (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire wst_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_stall_i,
  output wst_pkg::rsp_t      rsp_o
);
  import wst_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam int TBL_DEPTH = 1 << SEM_AW;

  logic [2:0] state_q, state_d;
  req_t req_q;
  logic [FREE_W-1:0] free_q, free_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [1:0] status_q, status_d;
  logic queued_q, queued_d;
  logic woke_q, woke_d;
  logic [WAITER_W-1:0] wid_q, wid_d;
  logic rsp_valid_q;
  rsp_t rsp_q;
  logic [TBL_DEPTH-1:0] tv_q;

  logic accept;
  logic [SEM_AW-1:0] sem_addr;
  logic in_range;

  logic tbl_we, tbl_re;
  sem_ent_t tbl_wdata, tbl_rdata, ent;
  logic [SEM_AW-1:0] tbl_raddr;

  logic q_we, q_re;
  logic [SLOT_W-1:0] q_wslot, q_rslot;
  q_ent_t q_wdata, q_rdata;

  logic [FREE_W-1:0] alu_a, alu_b, alu_res;
  logic alu_sub, alu_flag;

  logic [LEN_W:0] idx_p1, idx_p2;
  logic load_rsp;

  assign accept      = req_valid_i && !req_stall_o;
  assign req_stall_o = (state_q != S_IDLE);
  assign sem_addr    = SEM_AW'(req_q.sem_index);
  assign in_range    = (32'(req_q.sem_index) < NUM_SEMS);
  assign tbl_raddr   = SEM_AW'(req_i.sem_index);
  assign tbl_re      = accept;
  assign idx_p1      = (LEN_W + 1)'(idx_q) + (LEN_W + 1)'(1);
  assign idx_p2      = (LEN_W + 1)'(idx_q) + (LEN_W + 1)'(2);

  // entries never written read as inactive with an empty queue
  always_comb begin
    ent = tbl_rdata;
    if (!tv_q[sem_addr]) begin
      ent.active = 1'b0;
      ent.len    = '0;
    end
  end

  wst_ram #(
    .AW(SEM_AW),
    .DW($bits(sem_ent_t))
  ) u_tbl (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(sem_addr),
    .wdata_i(tbl_wdata),
    .re_i   (tbl_re),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  wst_ram #(
    .AW(SEM_AW + SLOT_W),
    .DW($bits(q_ent_t))
  ) u_queue (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i({sem_addr, q_wslot}),
    .wdata_i(q_wdata),
    .re_i   (q_re),
    .raddr_i({sem_addr, q_rslot}),
    .rdata_o(q_rdata)
  );

  wst_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .flag_o(alu_flag)
  );

  always_comb begin
    state_d   = state_q;
    free_d    = free_q;
    len_d     = len_q;
    idx_d     = idx_q;
    status_d  = status_q;
    queued_d  = queued_q;
    woke_d    = woke_q;
    wid_d     = wid_q;
    tbl_we    = 1'b0;
    tbl_wdata = ent;
    q_we      = 1'b0;
    q_wslot   = idx_q;
    q_wdata   = q_rdata;
    q_re      = 1'b0;
    q_rslot   = '0;
    alu_a     = ent.free;
    alu_b     = FREE_W'(req_q.amount);
    alu_sub   = 1'b1;
    load_rsp  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          queued_d = 1'b0;
          woke_d   = 1'b0;
          wid_d    = '0;
          state_d  = S_RD;
        end
      end
      S_RD: begin
        state_d = S_FIN;
        alu_sub = (req_q.operation != OP_SIGNAL);
        if (!in_range) begin
          status_d = ST_REJECT;
        end else if (req_q.operation == OP_DESTROY) begin
          tbl_we           = 1'b1;
          tbl_wdata.active = 1'b0;
        end else if (req_q.amount == '0) begin
          status_d = ST_REJECT;
        end else if (req_q.operation == OP_INIT) begin
          if (ent.active) begin
            status_d = ST_REJECT;
          end else begin
            tbl_we           = 1'b1;
            tbl_wdata.active = 1'b1;
            tbl_wdata.free   = FREE_W'(req_q.amount);
          end
        end else if (!ent.active) begin
          status_d = ST_REJECT;
        end else if (req_q.operation == OP_WAIT) begin
          if (!alu_flag) begin
            tbl_we         = 1'b1;
            tbl_wdata.free = alu_res;
          end else if (ent.len >= LEN_W'(WAIT_DEPTH)) begin
            status_d = ST_FULL;
          end else begin
            q_we           = 1'b1;
            q_wslot        = SLOT_W'(ent.len);
            q_wdata.amount = req_q.amount;
            q_wdata.waiter = req_q.waiter_id;
            tbl_we         = 1'b1;
            tbl_wdata.len  = ent.len + LEN_W'(1);
            queued_d       = 1'b1;
          end
        end else begin
          free_d = alu_flag ? '1 : alu_res;
          len_d  = ent.len;
          if (ent.len == '0) begin
            tbl_we         = 1'b1;
            tbl_wdata.free = alu_flag ? '1 : alu_res;
          end else begin
            q_re    = 1'b1;
            q_rslot = '0;
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        alu_a            = free_q;
        alu_b            = FREE_W'(q_rdata.amount);
        alu_sub          = 1'b1;
        tbl_wdata.active = 1'b1;
        tbl_wdata.free   = free_q;
        tbl_wdata.len    = len_q;
        if (!alu_flag) begin
          woke_d         = 1'b1;
          wid_d          = q_rdata.waiter;
          tbl_we         = 1'b1;
          tbl_wdata.free = alu_res;
          tbl_wdata.len  = len_q - LEN_W'(1);
          if (idx_p1 < (LEN_W + 1)'(len_q)) begin
            q_re    = 1'b1;
            q_rslot = SLOT_W'(idx_p1);
            state_d = S_SHIFT;
          end else begin
            state_d = S_FIN;
          end
        end else if (idx_p1 < (LEN_W + 1)'(len_q)) begin
          q_re    = 1'b1;
          q_rslot = SLOT_W'(idx_p1);
          idx_d   = SLOT_W'(idx_p1);
        end else begin
          tbl_we   = 1'b1;
          status_d = ST_NONE;
          state_d  = S_FIN;
        end
      end
      S_SHIFT: begin
        q_we    = 1'b1;
        q_wslot = idx_q;
        q_wdata = q_rdata;
        if (idx_p2 < (LEN_W + 1)'(len_q)) begin
          q_re    = 1'b1;
          q_rslot = SLOT_W'(idx_p2);
          idx_d   = SLOT_W'(idx_p1);
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!rsp_valid_q || !rsp_stall_i) begin
          load_rsp = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      tv_q        <= '0;
    end else begin
      state_q <= state_d;
      if (tbl_we) begin
        tv_q[sem_addr] <= 1'b1;
      end
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    free_q   <= free_d;
    len_q    <= len_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    queued_q <= queued_d;
    woke_q   <= woke_d;
    wid_q    <= wid_d;
    if (load_rsp) begin
      rsp_q.status     <= status_q;
      rsp_q.queued     <= queued_q;
      rsp_q.woke_valid <= woke_q;
      rsp_q.woke_id    <= wid_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_accept_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RD))
    else $error("accepted request did not start a table read");

  a_scan_in_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (LEN_W'(idx_q) < len_q))
    else $error("queue scan ran past the queue length");

  a_shift_after_grant : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> woke_q)
    else $error("compaction without a granted waiter");

  a_queued_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.queued || rsp_o.woke_valid)) |-> (rsp_o.status == ST_OK))
    else $error("queued or woke flag with a failing status");

  a_one_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.queued && rsp_o.woke_valid))
    else $error("result both queued and woke a waiter");

endmodule

`default_nettype wire

// File: verif/weighted_semaphore_table_tb.sv
// testbench for weighted_semaphore_table: directed and random requests checked against a predictor
`default_nettype none

module weighted_semaphore_table_tb;
  import wst_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 2 * WAIT_DEPTH + 8;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned SAT_SEM = 40;
  localparam int unsigned BIG_STEPS = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  rsp_t rsp_o;

  weighted_semaphore_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  bit                  sem_active  [NUM_SEMS];
  logic [FREE_W-1:0]   sem_free    [NUM_SEMS];
  int unsigned         wait_len    [NUM_SEMS];
  logic [AMOUNT_W-1:0] wait_amount [NUM_SEMS][WAIT_DEPTH];
  logic [WAITER_W-1:0] wait_who    [NUM_SEMS][WAIT_DEPTH];

  rsp_t        expected_rsp_q [$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit          calm_mode = 1'b0;

  function automatic rsp_t predict_result(req_t r);
    rsp_t        res;
    int unsigned s;
    int unsigned len;
    int unsigned hit;
    int unsigned j;
    logic [FREE_W:0] sum;
    res = '0;
    s = r.sem_index;
    if (s >= NUM_SEMS) begin
      res.status = ST_REJECT;
    end else if (r.operation == OP_DESTROY) begin
      sem_active[s] = 1'b0;
    end else if (r.amount == '0) begin
      res.status = ST_REJECT;
    end else if (r.operation == OP_INIT) begin
      if (sem_active[s]) begin
        res.status = ST_REJECT;
      end else begin
        sem_active[s] = 1'b1;
        sem_free[s] = FREE_W'(r.amount);
      end
    end else if (!sem_active[s]) begin
      res.status = ST_REJECT;
    end else if (r.operation == OP_WAIT) begin
      len = wait_len[s];
      if (sem_free[s] >= FREE_W'(r.amount)) begin
        sem_free[s] = sem_free[s] - FREE_W'(r.amount);
      end else if (len >= WAIT_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        wait_amount[s][len] = r.amount;
        wait_who[s][len] = r.waiter_id;
        wait_len[s] = len + 1;
        res.queued = 1'b1;
      end
    end else begin
      len = wait_len[s];
      sum = {1'b0, sem_free[s]} + (FREE_W + 1)'(r.amount);
      sem_free[s] = sum[FREE_W] ? '1 : sum[FREE_W-1:0];
      if (len != 0) begin
        hit = len;
        for (j = 0; j < len && hit == len; j++) begin
          if (FREE_W'(wait_amount[s][j]) <= sem_free[s]) hit = j;
        end
        if (hit < len) begin
          sem_free[s] = sem_free[s] - FREE_W'(wait_amount[s][hit]);
          res.woke_valid = 1'b1;
          res.woke_id = wait_who[s][hit];
          for (j = hit; j + 1 < len; j++) begin
            wait_amount[s][j] = wait_amount[s][j + 1];
            wait_who[s][j] = wait_who[s][j + 1];
          end
          wait_len[s] = len - 1;
        end else begin
          res.status = ST_NONE;
        end
      end
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [1:0] op, input int unsigned idx,
                              input int unsigned amt, input int unsigned who);
    req_t        r;
    int unsigned gap;
    r.operation = op;
    r.sem_index = SEM_IDX_W'(idx);
    r.amount = AMOUNT_W'(amt);
    r.waiter_id = WAITER_W'(who);
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (req_stall_o);
    expected_rsp_q.push_back(predict_result(r));
  endtask

  task automatic drop_request();
    @(negedge clk_i);
    req_valid_i <= 1'b0;
  endtask

  task automatic wait_for_drain();
    drop_request();
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && rsp_valid_o === 1'b1 && !rsp_stall_i) begin
      if (expected_rsp_q.size() == 0) begin
        $error("result with no request pending: %h", rsp_o);
        fail_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("status", want.status, rsp_o.status);
        check_field("queued", want.queued, rsp_o.queued);
        check_field("woke_valid", want.woke_valid, rsp_o.woke_valid);
        check_field("woke_id", want.woke_id, rsp_o.woke_id);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid_i && req_stall_o === 1'b0) || (rsp_valid_o === 1'b1 && !rsp_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_stall_gen
    int unsigned n;
    forever begin
      n = pick_gap();
      if (n != 0) begin
        @(negedge clk_i);
        rsp_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      rsp_stall_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  task automatic test_init_destroy();
    send_request(OP_INIT, 0, 0, 8'h00);
    send_request(OP_INIT, 0, 1, 8'h01);
    send_request(OP_INIT, 0, 5, 8'h02);
    send_request(OP_DESTROY, 0, 0, 8'h03);
    send_request(OP_DESTROY, 0, 7, 8'h04);
    send_request(OP_INIT, 63, 16'hFFFF, 8'hFF);
    send_request(OP_INIT, 0, 3, 8'h80);
  endtask

  task automatic test_wait_queue();
    int unsigned amounts [WAIT_DEPTH];
    amounts = '{4, 1, 2, 6, 7, 8, 9, 10};
    send_request(OP_WAIT, 5, 1, 8'h10);
    send_request(OP_WAIT, 0, 0, 8'h11);
    send_request(OP_WAIT, 0, 3, 8'h00);
    foreach (amounts[i]) send_request(OP_WAIT, 0, amounts[i], 8'hF0 + i);
    send_request(OP_WAIT, 0, 1, 8'hFF);
  endtask

  task automatic test_signal_grant();
    send_request(OP_SIGNAL, 0, 0, 8'h20);
    send_request(OP_SIGNAL, 5, 1, 8'h21);
    // grant from the middle of the list, then nothing fits, then a second grant from the middle
    send_request(OP_SIGNAL, 0, 1, 8'h22);
    send_request(OP_SIGNAL, 0, 1, 8'h23);
    send_request(OP_SIGNAL, 0, 1, 8'h24);
    // list survives destroy and re-init
    send_request(OP_DESTROY, 0, 0, 8'h25);
    send_request(OP_SIGNAL, 0, 1, 8'h26);
    send_request(OP_INIT, 0, 1, 8'h27);
    send_request(OP_SIGNAL, 0, 16'hFFFF, 8'h28);
  endtask

  task automatic test_large_free();
    int unsigned k;
    wait_for_drain();
    calm_mode = 1'b1;
    send_request(OP_INIT, SAT_SEM, 16'hFFFF, 8'h30);
    for (k = 0; k < BIG_STEPS; k++) send_request(OP_SIGNAL, SAT_SEM, 16'hFFFF, k);
    for (k = 0; k < BIG_STEPS; k++) send_request(OP_WAIT, SAT_SEM, 16'hFFFF, k);
    send_request(OP_WAIT, SAT_SEM, 1, 8'hA5);
    send_request(OP_SIGNAL, SAT_SEM, 1, 8'h5A);
    send_request(OP_DESTROY, SAT_SEM, 0, 8'h00);
    wait_for_drain();
    calm_mode = 1'b0;
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned pool [4];
    int unsigned n;
    int unsigned idx;
    int unsigned amt;
    int unsigned roll;
    logic [1:0]  op;
    for (n = 0; n < count; n++) begin
      if (n % 250 == 0) begin
        foreach (pool[i]) pool[i] = $urandom_range(0, NUM_SEMS - 1);
        calm_mode = ($urandom_range(0, 3) == 0);
      end
      if (n == count / 2 || $urandom_range(0, 99) == 0) wait_for_drain();
      idx = pool[$urandom_range(0, 3)];
      roll = $urandom_range(0, 99);
      amt = (roll < 5) ? 0 : (roll < 10) ? $urandom_range(13, 65535) : $urandom_range(1, 12);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        op = 2'($urandom_range(0, 3));
        idx = $urandom_range(0, NUM_SEMS - 1);
        amt = $urandom_range(0, 65535);
      end else if (!sem_active[idx]) begin
        op = (roll < 18) ? 2'($urandom_range(0, 3)) : OP_INIT;
      end else if (roll < 12) begin
        op = OP_DESTROY;
      end else if (roll < 17) begin
        op = OP_INIT;
      end else if (roll < 58) begin
        op = OP_WAIT;
      end else begin
        op = OP_SIGNAL;
      end
      send_request(op, idx, amt, $urandom_range(0, 255));
    end
    calm_mode = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_init_destroy();
    test_wait_queue();
    test_signal_grant();
    test_large_free();
    test_random_traffic(RANDOM_ITEMS);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_rsp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
